[rtl/core/ksa_pkg.sv]
// Package for the shared-array stack core: payload structs, sizes and codes.
// Used by k_stacks_shared_array_core; no dependencies.
package ksa_pkg;

  localparam int STACKS  = 4;
  localparam int ENTRIES = 16;

  // Entry index carries one extra code, ENTRIES itself, meaning "no entry".
  localparam int IDX_W  = $clog2(ENTRIES + 1);
  localparam int ADDR_W = $clog2(ENTRIES);
  localparam int SIDX_W = (STACKS > 1) ? $clog2(STACKS) : 1;

  localparam logic [IDX_W-1:0] NULL_IDX = IDX_W'(ENTRIES);

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic signed [31:0] EMPTY_DATA = 32'sh7FFF_FFFF;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         stack_id;
    logic signed [31:0] item;
  } in_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
  } out_t;

endpackage

[rtl/core/ksa_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module ksa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/k_stacks_shared_array_core.sv]
// Several LIFO stacks sharing one entry store through a linked free list.
// Depends on ksa_pkg and ksa_ram (item store and link store).
//
// A push or pop that can proceed reads the link memory at the selected
// entry in the accept cycle; the next cycle updates the head registers and
// writes the link back. A push that finds no free entry or names a stack
// out of range, and a pop from an empty or out-of-range stack, finish in the
// accept cycle. No new operation is taken while one is executing; the result
// register lets the next transfer in while the previous result is being
// taken. Link memory reads as its reset chain through per-entry valid bits,
// so no clearing pass is needed after reset.
module k_stacks_shared_array_core
  import ksa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_q, state_d;

  logic [IDX_W-1:0] heads_q [STACKS];
  logic [IDX_W-1:0] free_head_q, free_head_d;
  logic [ENTRIES-1:0] lvalid_q;

  logic [IDX_W-1:0] e_q, head_q;
  logic             push_q;
  logic [SIDX_W-1:0] sid_q;

  logic out_valid_q, out_valid_d;
  out_t out_q, out_d;

  logic             accept, is_push, sid_ok, op_ok, in_exec;
  logic [SIDX_W-1:0] sid_idx;
  logic [IDX_W-1:0] sel_head, e_acc, link_rd, link_rst, link_nxt;
  logic signed [31:0] item_rd;

  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign in_exec    = (state_q == S_EXEC);

  assign sid_idx  = in_data_i.stack_id[SIDX_W-1:0];
  assign sid_ok   = int'(in_data_i.stack_id) < STACKS;
  assign sel_head = sid_ok ? heads_q[sid_idx] : NULL_IDX;
  assign is_push  = (in_data_i.cmd == CMD_PUSH);
  assign e_acc    = is_push ? free_head_q : sel_head;
  assign op_ok    = sid_ok && (e_acc != NULL_IDX);

  ksa_ram #(
    .WIDTH (32),
    .DEPTH (ENTRIES)
  ) u_item_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_push && op_ok),
    .waddr_i (e_acc[ADDR_W-1:0]),
    .wdata_i (in_data_i.item),
    .re_i    (accept && !is_push && op_ok),
    .raddr_i (e_acc[ADDR_W-1:0]),
    .rdata_o (item_rd)
  );

  ksa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (ENTRIES)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (in_exec),
    .waddr_i (e_q[ADDR_W-1:0]),
    .wdata_i (push_q ? head_q : free_head_q),
    .re_i    (accept && op_ok),
    .raddr_i (e_acc[ADDR_W-1:0]),
    .rdata_o (link_rd)
  );

  // Unwritten link entries follow the reset chain i -> i+1, last -> null.
  assign link_rst = (e_q == IDX_W'(ENTRIES - 1)) ? NULL_IDX : e_q + IDX_W'(1);
  assign link_nxt = lvalid_q[e_q[ADDR_W-1:0]] ? link_rd : link_rst;

  always_comb begin
    state_d     = state_q;
    free_head_d = free_head_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_ok) begin
            state_d = S_EXEC;
          end else begin
            out_valid_d = 1'b1;
            out_d.data   = is_push ? 32'sd0 : EMPTY_DATA;
            out_d.status = is_push ? ST_FULL : ST_EMPTY;
          end
        end
      end
      S_EXEC: begin
        state_d      = S_IDLE;
        out_valid_d  = 1'b1;
        out_d.status = ST_OK;
        if (push_q) begin
          free_head_d = link_nxt;
          out_d.data  = 32'sd0;
        end else begin
          free_head_d = e_q;
          out_d.data  = item_rd;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      lvalid_q    <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < STACKS; i++) begin
        heads_q[i] <= NULL_IDX;
      end
    end else begin
      state_q     <= state_d;
      free_head_q <= free_head_d;
      out_valid_q <= out_valid_d;
      if (in_exec) begin
        lvalid_q[e_q[ADDR_W-1:0]] <= 1'b1;
        heads_q[sid_q] <= push_q ? e_q : link_nxt;
      end
    end
  end

  // Operation context held across the link read.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      e_q    <= e_acc;
      head_q <= sel_head;
      push_q <= is_push;
      sid_q  <= sid_idx;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |=> state_q == S_IDLE)
    else $error("execute state lasted more than one cycle");

  a_exec_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> !out_valid_q)
    else $error("result register occupied during execute");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC |-> !in_ready_o)
    else $error("input taken while an operation is in flight");

  a_free_head_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_head_q <= NULL_IDX)
    else $error("free list head out of range");

  a_empty_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == ST_EMPTY |-> out_q.data == EMPTY_DATA)
    else $error("empty pop result carries wrong data");
`endif

endmodule

[bench/k_stacks_shared_array_core_test.sv]
// Self-checking bench for k_stacks_shared_array_core: directed and random push/pop traffic
// with a scoreboard that tracks the shared entry store, free list and stack tops.
// Depends on ksa_pkg and the core RTL only.
module k_stacks_shared_array_core_test;
  import ksa_pkg::*;

  class stack_scoreboard;
    logic [IDX_W-1:0]   top_of  [STACKS];
    logic [IDX_W-1:0]   next_of [ENTRIES];
    logic [IDX_W-1:0]   free_top;
    logic signed [31:0] slot_val [ENTRIES];
    out_t               want_q [$];
    int errors, n_checked, n_stored, n_full, n_popped, n_empty;

    function new();
      for (int i = 0; i < ENTRIES; i++) begin
        next_of[i]  = IDX_W'(i + 1);
        slot_val[i] = '0;
      end
      for (int s = 0; s < STACKS; s++) top_of[s] = NULL_IDX;
      free_top  = '0;
      errors    = 0;
      n_checked = 0;
      n_stored  = 0;
      n_full    = 0;
      n_popped  = 0;
      n_empty   = 0;
    endfunction

    function int pending();
      return want_q.size();
    endfunction

    // Apply one accepted operation to the shadow state and queue its answer.
    function void note_input(in_t op);
      out_t             want;
      logic [IDX_W-1:0] e;
      want.data   = '0;
      want.status = ST_OK;
      if (op.cmd == CMD_PUSH) begin
        if (int'(op.stack_id) >= STACKS || int'(free_top) >= ENTRIES) begin
          want.status = ST_FULL;
          n_full++;
        end else begin
          e                    = free_top;
          free_top             = next_of[e];
          next_of[e]           = top_of[op.stack_id];
          top_of[op.stack_id]  = e;
          slot_val[e]          = op.item;
          n_stored++;
        end
      end else begin
        if (int'(op.stack_id) >= STACKS || int'(top_of[op.stack_id]) >= ENTRIES) begin
          want.data   = EMPTY_DATA;
          want.status = ST_EMPTY;
          n_empty++;
        end else begin
          e                   = top_of[op.stack_id];
          top_of[op.stack_id] = next_of[e];
          next_of[e]          = free_top;
          free_top            = e;
          want.data           = slot_val[e];
          n_popped++;
        end
      end
      want_q.push_back(want);
    endfunction

    task report(string what);
      if (errors < 50) $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (want_q.size() == 0) begin
        report($sformatf("result with nothing pending: data=%0d status=%0d",
                         got.data, got.status));
        return;
      end
      want = want_q.pop_front();
      n_checked++;
      if (got.data !== want.data)
        report($sformatf("result %0d data got %0d want %0d", n_checked, got.data, want.data));
      if (got.status !== want.status)
        report($sformatf("result %0d status got %0d want %0d",
                         n_checked, got.status, want.status));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  stack_scoreboard sb = new();

  k_stacks_shared_array_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Note inputs before checking outputs so the oldest expectation is always at the front.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_input(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
    end
  end

  function automatic in_t make_op(logic cmd, int sid, logic signed [31:0] value);
    in_t op;
    op.cmd      = cmd;
    op.stack_id = SIDX_W'(sid);
    op.item     = value;
    return op;
  endfunction

  task automatic send_op(input in_t op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= op;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Hold off new transfers until every queued answer has come back.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_directed();
    // Pops on empty stacks, one with every item bit set to show the item is ignored.
    send_op(make_op(CMD_POP, 0, '1));
    send_op(make_op(CMD_POP, STACKS - 1, '0));
    send_op(make_op(CMD_PUSH, 0, 32'sh8000_0000));
    send_op(make_op(CMD_PUSH, 1, 32'sh7FFF_FFFF));
    send_op(make_op(CMD_PUSH, 2, -32'sd1));
    send_op(make_op(CMD_PUSH, 3, 32'sd0));
    // Fill the rest of the store, then push once more into a full store.
    for (int i = 4; i < ENTRIES; i++)
      send_op(make_op(CMD_PUSH, i % STACKS, 32'sh5A5A_0000 + i));
    send_op(make_op(CMD_PUSH, 2, 32'sd123));
    for (int s = 0; s < STACKS; s++)
      send_op(make_op(CMD_POP, s, '1));
    send_op(make_op(CMD_PUSH, 1, 32'sh1234_5678));
  endtask

  task automatic run_random(input int count, input int pause_at);
    int  push_pct;
    int  fav;
    in_t op;
    push_pct = 50;
    fav      = 0;
    for (int n = 0; n < count; n++) begin
      // Swing between filling and draining so both full and empty show up often.
      if (n % 32 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 85;
          1:       push_pct = 50;
          default: push_pct = 15;
        endcase
        fav = $urandom_range(STACKS - 1);
      end
      if (n == pause_at) wait_drained();
      op.cmd      = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
      op.stack_id = SIDX_W'($urandom_range(1) ? fav : $urandom_range(STACKS - 1));
      case ($urandom_range(9))
        0:       op.item = 32'sh8000_0000;
        1:       op.item = 32'sh7FFF_FFFF;
        2:       op.item = '1;
        3:       op.item = '0;
        default: op.item = $urandom;
      endcase
      send_op(op);
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_data_i  = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();
    wait_drained();

    send_idle_pct  = 24;
    recv_stall_pct = 87;
    run_random(209, -1);
    wait_drained();

    send_idle_pct  = 87;
    recv_stall_pct = 24;
    run_random(209, 100);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(209, -1);
    wait_drained();
    repeat (8) @(posedge clk_i);

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("run covered %0d operations: %0d pushes stored, %0d pushes refused as full,",
             sb.n_checked, sb.n_stored, sb.n_full);
    $display("  %0d pops returned data, %0d pops on empty stacks, %0d mismatches",
             sb.n_popped, sb.n_empty, sb.errors);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/ksa_pkg.sv
rtl/core/ksa_ram.sv
rtl/core/k_stacks_shared_array_core.sv
bench/k_stacks_shared_array_core_test.sv
